FILE: rtl/sfr_pkg.sv
// shared types and constants for the stream find-and-replace block
package sfr_pkg;

  // byte slots of the packed pattern and replacement registers
  localparam int unsigned BYTE_SLOTS  = 8;
  localparam int unsigned SLOT_CNT_W  = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;

  // configuration register indexes
  localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        end_of_output;
    logic [31:0] hit_total;
  } out_item_t;

  // one command from the front end: the bytes this input produces
  typedef struct packed {
    logic [BYTE_SLOTS-1:0][7:0] out_bytes;
    logic [SLOT_CNT_W-1:0]      byte_count;
    logic                       last;
    logic [31:0]                hit_total;
  } cmd_t;

endpackage

FILE: rtl/sfr_front.sv
// front end: config registers, match window, compare and command build
module sfr_front #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned REPLACE_MAX = 8,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [63:0]       wr_data,
  input  logic              accept,
  input  sfr_pkg::in_item_t item,
  output logic              cmd_push,
  output sfr_pkg::cmd_t     cmd
);
  import sfr_pkg::*;

  localparam int unsigned DEPTH  = PATTERN_MAX;
  localparam int unsigned FILL_W = $clog2(PATTERN_MAX + 1);

  logic [63:0]            pattern_bytes;
  logic [3:0]             pattern_length;
  logic [63:0]            replacement_bytes;
  logic [3:0]             replacement_length;
  logic [DEPTH-1:0][7:0]  window;
  logic [DEPTH-1:0][7:0]  window_next;
  logic [DEPTH-1:0][7:0]  win_ins;
  logic [FILL_W-1:0]      fill;
  logic [FILL_W-1:0]      fill_next;
  logic [3:0]             fill_ins;
  logic [COUNT_WIDTH-1:0] match_count;
  logic [COUNT_WIDTH-1:0] count_bumped;
  logic [3:0]             plen;
  logic [3:0]             plen_new;
  logic [3:0]             rlen;
  logic                   full_win;
  logic                   hit;
  logic                   replace;

  // clamp helpers for the length registers
  always_comb begin
    plen = pattern_length;
    if (plen == 4'd0) plen = 4'd1;
    if (plen > 4'(PATTERN_MAX)) plen = 4'(PATTERN_MAX);
    plen_new = wr_data[3:0];
    if (plen_new == 4'd0) plen_new = 4'd1;
    if (plen_new > 4'(PATTERN_MAX)) plen_new = 4'(PATTERN_MAX);
    rlen = replacement_length;
    if (rlen > 4'(REPLACE_MAX)) rlen = 4'(REPLACE_MAX);
  end

  // window with the new byte appended, then the pattern compare
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      win_ins[k] = (fill == FILL_W'(k)) ? item.data_byte : window[k];
    end
    fill_ins = 4'(fill) + 4'd1;
    full_win = (fill_ins == plen);
    hit = 1'b1;
    for (int k = 0; k < DEPTH; k++) begin
      if ((4'(k) < plen) && (win_ins[k] != pattern_bytes[8*k +: 8])) hit = 1'b0;
    end
    replace = full_win && hit;
  end

  always_comb begin
    count_bumped = match_count;
    if (replace && (match_count != '1)) count_bumped = match_count + 1'b1;
  end

  // command: replacement, oldest byte, and on the last byte the flushed rest
  always_comb begin
    cmd.out_bytes = '0;
    if (replace) begin
      cmd.out_bytes = replacement_bytes;
      cmd.byte_count = rlen;
    end else begin
      for (int k = 0; k < DEPTH; k++) cmd.out_bytes[k] = win_ins[k];
      if (item.last_byte) cmd.byte_count = fill_ins;
      else cmd.byte_count = full_win ? 4'd1 : 4'd0;
    end
    cmd.last      = item.last_byte;
    cmd.hit_total = 32'(count_bumped);
    cmd_push      = accept && ((cmd.byte_count != 4'd0) || item.last_byte);
  end

  always_comb begin
    window_next = win_ins;
    fill_next   = FILL_W'(fill_ins);
    if (replace || item.last_byte) begin
      fill_next = '0;
    end else if (full_win) begin
      for (int k = 0; k + 1 < DEPTH; k++) window_next[k] = win_ins[k+1];
      window_next[DEPTH-1] = 8'd0;
      fill_next = FILL_W'(fill_ins - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= 4'd1;
      replacement_bytes  <= '0;
      replacement_length <= '0;
      window             <= '0;
      fill               <= '0;
      match_count        <= '0;
    end else begin
      if (accept) begin
        window      <= window_next;
        fill        <= fill_next;
        match_count <= item.last_byte ? '0 : count_bumped;
      end
      if (wr_en) begin
        case (wr_index)
          REG_PATTERN_BYTES:      pattern_bytes <= wr_data;
          REG_PATTERN_LENGTH: begin
            pattern_length <= wr_data[3:0];
            // buffered bytes cannot stay once the window would be over-full
            if (4'(fill) >= plen_new) fill <= '0;
          end
          REG_REPLACEMENT_BYTES:  replacement_bytes <= wr_data;
          REG_REPLACEMENT_LENGTH: replacement_length <= wr_data[3:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: rtl/sfr_queue.sv
// short command queue between front end and back end
module sfr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output sfr_pkg::cmd_t head,
  output logic          empty
);
  import sfr_pkg::*;

  cmd_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   used;
  logic                   do_push;
  logic                   do_pop;

  assign full    = (used == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (used == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) used <= used + 1'b1;
      else if (do_pop && !do_push) used <= used - 1'b1;
    end
  end

endmodule

FILE: rtl/sfr_back.sv
// back end: walks each command one byte per cycle into the output register while the receiver pops
module sfr_back (
  input  logic               clk,
  input  logic               rst,
  input  sfr_pkg::cmd_t      head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output sfr_pkg::out_item_t result
);
  import sfr_pkg::*;

  logic [2:0]  idx;
  logic        out_valid;
  logic        load;
  logic        final_byte;
  out_item_t   next_item;

  always_comb begin
    load       = !q_empty && (!out_valid || pop);
    final_byte = (head.byte_count == '0) || ({1'b0, idx} == head.byte_count - 4'd1);
    next_item.out_byte      = (head.byte_count == '0) ? 8'd0 : head.out_bytes[idx];
    next_item.byte_valid    = (head.byte_count != '0);
    next_item.end_of_output = head.last && final_byte;
    next_item.hit_total     = head.hit_total;
    q_pop = load && final_byte;
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (load) result <= next_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_byte ? 3'd0 : idx + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/stream_find_replace.sv
// top level of the streaming find-and-replace-all block
//
// input queue side: an item (one string byte plus a last flag) transfers on a
// clock edge with push high and full low. result side: the oldest result sits
// on result while empty is low and transfers on an edge with pop high.
// config: wr_en writes wr_data into register wr_index (0 pattern bytes,
// 1 pattern length, 2 replacement bytes, 3 replacement length);
// write only while no string is in flight.
// each input byte gives zero, one or up to eight result bytes; the last byte
// of a string always ends with a result marked end_of_output, a bare marker
// if nothing is left. the first result of a byte passes through the command
// queue and the output register before it reaches the result ports. the
// block takes one input byte per cycle while each byte yields at most one
// result and the receiver keeps popping; the back end drains one result per
// cycle while pop is high, so replacement bursts and end-of-string flushes
// fill the four-entry command queue and raise full until it drains.
// a stalled receiver holds the output register, then the queue fills and
// full rises; nothing is dropped. synchronous reset clears the window, the
// hit count, the queue and the config registers (pattern length back to one).
module stream_find_replace #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned REPLACE_MAX = 8,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  sfr_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output sfr_pkg::out_item_t result,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [63:0]        wr_data
);
  import sfr_pkg::*;

  logic accept;
  logic cmd_push;
  cmd_t cmd;
  cmd_t head;
  logic q_empty;
  logic q_pop;

  // an input transfers only when the command queue has room
  assign accept = push && !full;

  sfr_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .accept   (accept),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  // commands carry the bytes each input produces plus end mark and hit count
  sfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd),
    .full     (full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  sfr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
